// ===== rtl/ps2kbd_pkg.sv =====
package ps2kbd_pkg;

    // Scan code translation table length; codes at or above give no character
    localparam int TABLE_LEN = 86;

    // Set-1 make codes (low 7 bits)
    localparam logic [6:0] KEY_NUM    = 7'h45;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_SCROLL = 7'h46;
    localparam logic [6:0] KEY_F12    = 7'h58;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_LSHIFT = 7'd42;
    localparam logic [6:0] KEY_RSHIFT = 7'd54;
    localparam logic [6:0] KEY_ALT    = 7'd56;

    // Indicator byte bit positions
    localparam int LED_SCROLL = 0;
    localparam int LED_NUM    = 1;
    localparam int LED_CAPS   = 2;

    // Debugger lock bit positions
    localparam int DBG_NUM  = 0;
    localparam int DBG_CAPS = 1;

    // Result packing
    typedef struct packed {
        logic       hotkey;
        logic [2:0] led_bits;
        logic       led_write;
        logic       is_release;
        logic [6:0] ascii_code;
    } kbd_result_t;

    // Unshifted table
    function automatic logic [6:0] plain_ascii(input logic [6:0] code);
        logic [6:0] ch;
        ch = 7'd0;
        case (code)
            7'd2:  ch = 7'h31;
            7'd3:  ch = 7'h32;
            7'd4:  ch = 7'h33;
            7'd5:  ch = 7'h34;
            7'd6:  ch = 7'h35;
            7'd7:  ch = 7'h36;
            7'd8:  ch = 7'h37;
            7'd9:  ch = 7'h38;
            7'd10: ch = 7'h39;
            7'd11: ch = 7'h30;
            7'd12: ch = 7'h2D;
            7'd13: ch = 7'h3D;
            7'd16: ch = 7'h71;
            7'd17: ch = 7'h77;
            7'd18: ch = 7'h65;
            7'd19: ch = 7'h72;
            7'd20: ch = 7'h74;
            7'd21: ch = 7'h79;
            7'd22: ch = 7'h75;
            7'd23: ch = 7'h69;
            7'd24: ch = 7'h6F;
            7'd25: ch = 7'h70;
            7'd26: ch = 7'h5B;
            7'd27: ch = 7'h5D;
            7'd28: ch = 7'h0A;
            7'd30: ch = 7'h61;
            7'd31: ch = 7'h73;
            7'd32: ch = 7'h64;
            7'd33: ch = 7'h66;
            7'd34: ch = 7'h67;
            7'd35: ch = 7'h68;
            7'd36: ch = 7'h6A;
            7'd37: ch = 7'h6B;
            7'd38: ch = 7'h6C;
            7'd39: ch = 7'h3B;
            7'd40: ch = 7'h27;
            7'd41: ch = 7'h60;
            7'd43: ch = 7'h5C;
            7'd44: ch = 7'h7A;
            7'd45: ch = 7'h78;
            7'd46: ch = 7'h63;
            7'd47: ch = 7'h76;
            7'd48: ch = 7'h62;
            7'd49: ch = 7'h6E;
            7'd50: ch = 7'h6D;
            7'd51: ch = 7'h2C;
            7'd52: ch = 7'h2E;
            7'd53: ch = 7'h2F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            7'd71: ch = 7'h37;
            7'd72: ch = 7'h38;
            7'd73: ch = 7'h39;
            7'd74: ch = 7'h2D;
            7'd75: ch = 7'h34;
            7'd76: ch = 7'h35;
            7'd77: ch = 7'h36;
            7'd78: ch = 7'h2B;
            7'd79: ch = 7'h31;
            7'd80: ch = 7'h32;
            7'd81: ch = 7'h33;
            7'd82: ch = 7'h30;
            7'd83: ch = 7'h2E;
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

    // Shifted table
    function automatic logic [6:0] shift_ascii(input logic [6:0] code);
        logic [6:0] ch;
        ch = 7'd0;
        case (code)
            7'd2:  ch = 7'h21;
            7'd3:  ch = 7'h40;
            7'd4:  ch = 7'h23;
            7'd5:  ch = 7'h24;
            7'd6:  ch = 7'h25;
            7'd7:  ch = 7'h5E;
            7'd8:  ch = 7'h26;
            7'd9:  ch = 7'h2A;
            7'd10: ch = 7'h28;
            7'd11: ch = 7'h29;
            7'd12: ch = 7'h5F;
            7'd13: ch = 7'h2B;
            7'd16: ch = 7'h51;
            7'd17: ch = 7'h57;
            7'd18: ch = 7'h45;
            7'd19: ch = 7'h52;
            7'd20: ch = 7'h54;
            7'd21: ch = 7'h59;
            7'd22: ch = 7'h55;
            7'd23: ch = 7'h49;
            7'd24: ch = 7'h4F;
            7'd25: ch = 7'h50;
            7'd26: ch = 7'h7B;
            7'd27: ch = 7'h7D;
            7'd28: ch = 7'h0A;
            7'd30: ch = 7'h41;
            7'd31: ch = 7'h53;
            7'd32: ch = 7'h44;
            7'd33: ch = 7'h46;
            7'd34: ch = 7'h47;
            7'd35: ch = 7'h48;
            7'd36: ch = 7'h4A;
            7'd37: ch = 7'h4B;
            7'd38: ch = 7'h4C;
            7'd39: ch = 7'h3A;
            7'd40: ch = 7'h22;
            7'd41: ch = 7'h7E;
            7'd43: ch = 7'h7C;
            7'd44: ch = 7'h5A;
            7'd45: ch = 7'h58;
            7'd46: ch = 7'h43;
            7'd47: ch = 7'h56;
            7'd48: ch = 7'h42;
            7'd49: ch = 7'h4E;
            7'd50: ch = 7'h4D;
            7'd51: ch = 7'h3C;
            7'd52: ch = 7'h3E;
            7'd53: ch = 7'h3F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            7'd71: ch = 7'h37;
            7'd72: ch = 7'h38;
            7'd73: ch = 7'h39;
            7'd74: ch = 7'h2D;
            7'd75: ch = 7'h34;
            7'd76: ch = 7'h35;
            7'd77: ch = 7'h36;
            7'd78: ch = 7'h2B;
            7'd79: ch = 7'h31;
            7'd80: ch = 7'h32;
            7'd81: ch = 7'h33;
            7'd82: ch = 7'h30;
            7'd83: ch = 7'h2E;
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/ps2_scan_code_keyboard_decoder.sv =====
// The result of an accepted scan code transaction is registered and shown on m_tdata in the next cycle.
// Throughput: one scan code per cycle while the result is taken (m_tready); the single result register and the
// modifier/lock flags are the only state between the two sides.
// Reset (rst_n, asynchronous): modifiers, system and debugger locks, the
// debugger mode register and the result valid are cleared.
module ps2_scan_code_keyboard_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: debugger_active
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_code
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [6:0] ascii_code, [7] is_release, [8] led_write,
                                   // [11:9] led_bits, [12] hotkey, [15:13] zero
);
    import ps2kbd_pkg::*;

    logic        dbg_active_reg;
    logic        shift_reg, shift_next;
    logic        ctrl_reg, ctrl_next;
    logic        alt_reg, alt_next;
    logic [2:0]  sys_locks_reg, sys_locks_next;
    logic [1:0]  dbg_locks_reg, dbg_locks_next;
    logic        out_valid_reg;
    kbd_result_t result_reg, result_next;

    logic        accept;
    logic        rel;
    logic [6:0]  key;
    logic        pressed;
    logic        in_table;
    logic        use_shift;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign rel      = s_tdata[7];
    assign key      = s_tdata[6:0];
    assign pressed  = !rel;
    assign in_table = ({1'b0, s_tdata} < 9'(TABLE_LEN));

    // Modifier, lock and hotkey evaluation, then translation with updated flags
    always_comb
    begin
        shift_next     = shift_reg;
        ctrl_next      = ctrl_reg;
        alt_next       = alt_reg;
        sys_locks_next = sys_locks_reg;
        dbg_locks_next = dbg_locks_reg;
        result_next    = '0;

        if (key == KEY_LSHIFT || key == KEY_RSHIFT)
        begin
            shift_next = pressed;
        end
        else if (key == KEY_CTRL)
        begin
            ctrl_next = pressed;
        end
        else if (key == KEY_ALT)
        begin
            alt_next = pressed;
        end

        if (dbg_active_reg)
        begin
            if (pressed && (key == KEY_NUM || key == KEY_CAPS))
            begin
                if (key == KEY_NUM)
                    dbg_locks_next[DBG_NUM] = !dbg_locks_reg[DBG_NUM];
                else
                    dbg_locks_next[DBG_CAPS] = !dbg_locks_reg[DBG_CAPS];
                result_next.led_write            = 1'b1;
                result_next.led_bits[LED_SCROLL] = 1'b1;
                result_next.led_bits[LED_NUM]    = dbg_locks_next[DBG_NUM];
                result_next.led_bits[LED_CAPS]   = dbg_locks_next[DBG_CAPS];
            end
        end
        else if (pressed)
        begin
            if (key == KEY_SCROLL)
                sys_locks_next[LED_SCROLL] = !sys_locks_reg[LED_SCROLL];
            else if (key == KEY_NUM)
                sys_locks_next[LED_NUM] = !sys_locks_reg[LED_NUM];
            else if (key == KEY_CAPS)
                sys_locks_next[LED_CAPS] = !sys_locks_reg[LED_CAPS];
            else if (key == KEY_F12 && shift_next && ctrl_next && alt_next)
            begin
                result_next.hotkey   = 1'b1;
                result_next.led_bits = sys_locks_reg;
            end
        end

        // table select: shift XOR debugger caps
        use_shift              = shift_next ^ dbg_locks_next[DBG_CAPS];
        result_next.is_release = rel;
        if (in_table)
            result_next.ascii_code = use_shift ? shift_ascii(key) : plain_ascii(key);
        else
            result_next.ascii_code = 7'd0;
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbg_active_reg <= 1'b0;
            shift_reg      <= 1'b0;
            ctrl_reg       <= 1'b0;
            alt_reg        <= 1'b0;
            sys_locks_reg  <= '0;
            dbg_locks_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                dbg_active_reg <= cfg_wdata;
            if (accept)
            begin
                shift_reg     <= shift_next;
                ctrl_reg      <= ctrl_next;
                alt_reg       <= alt_next;
                sys_locks_reg <= sys_locks_next;
                dbg_locks_reg <= dbg_locks_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import ps2kbd_pkg::*;

    localparam int SETTLE_CYCLES = 3;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASES        = 7;
    localparam int PHASE_KEYS    = 100;

    typedef enum logic [1:0] {ENT_KEY, ENT_CFG, ENT_DRAIN} entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic [7:0]  value;
    } stim_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] scan_code
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [6:0] ascii_code, [7] is_release, [8] led_write,
                                      // [11:9] led_bits, [12] hotkey

    stim_entry_t pending_q[$];
    kbd_result_t decoded_q[$];

    int keys_total = 0;
    int keys_sent = 0;
    int results_seen = 0;
    int error_count = 0;
    int gap_left = 0;
    int settle_left = 0;
    int stall_left = 0;
    bit drain_queued = 1'b0;

    // Predictor state
    logic       dbg_mode = 1'b0;
    logic       shift_st = 1'b0;
    logic       ctrl_st = 1'b0;
    logic       alt_st = 1'b0;
    logic [2:0] sys_lock_st = 3'b000;
    logic [1:0] dbg_lock_st = 2'b00;

    // Set-1 translation, unshifted and shifted
    logic [7:0] plain_tab [TABLE_LEN] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00
    };

    logic [7:0] shift_tab [TABLE_LEN] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00
    };

    ps2_scan_code_keyboard_decoder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decode one scan code: update modifiers and locks, then translate
    function automatic kbd_result_t decode_scan(input logic [7:0] code);
        kbd_result_t r;
        logic       rel;
        logic [6:0] key;
        logic       upper;
        r = '0;
        rel = code[7];
        key = code[6:0];

        // left and right shift share one flag, last one wins
        if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            shift_st = !rel;
        else if (key == KEY_CTRL)
            ctrl_st = !rel;
        else if (key == KEY_ALT)
            alt_st = !rel;

        if (dbg_mode)
        begin
            if (!rel && (key == KEY_NUM || key == KEY_CAPS))
            begin
                if (key == KEY_NUM)
                    dbg_lock_st[DBG_NUM] = !dbg_lock_st[DBG_NUM];
                else
                    dbg_lock_st[DBG_CAPS] = !dbg_lock_st[DBG_CAPS];
                r.led_write = 1'b1;
                r.led_bits[LED_SCROLL] = 1'b1;
                r.led_bits[LED_NUM] = dbg_lock_st[DBG_NUM];
                r.led_bits[LED_CAPS] = dbg_lock_st[DBG_CAPS];
            end
        end
        else if (!rel)
        begin
            if (key == KEY_SCROLL)
                sys_lock_st[LED_SCROLL] = !sys_lock_st[LED_SCROLL];
            else if (key == KEY_NUM)
                sys_lock_st[LED_NUM] = !sys_lock_st[LED_NUM];
            else if (key == KEY_CAPS)
                sys_lock_st[LED_CAPS] = !sys_lock_st[LED_CAPS];
            else if (key == KEY_F12 && shift_st && ctrl_st && alt_st)
            begin
                r.hotkey = 1'b1;
                r.led_bits = sys_lock_st;
            end
        end

        r.is_release = rel;
        upper = shift_st ^ dbg_lock_st[DBG_CAPS];
        if (code < TABLE_LEN)
            r.ascii_code = upper ? shift_tab[code][6:0] : plain_tab[code][6:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic add_key(input logic [7:0] code);
        pending_q.push_back('{kind: ENT_KEY, value: code});
        keys_total++;
    endtask

    task automatic add_cfg(input logic mode);
        pending_q.push_back('{kind: ENT_CFG, value: {7'd0, mode}});
    endtask

    // One random burst: mostly well-formed key sequences, some noise
    task automatic add_burst();
        int         pick;
        int         first;
        logic [6:0] chord [3];
        logic [6:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // typed key: press, then release in most bursts
            key = 7'($urandom_range(0, TABLE_LEN - 1));
            add_key({1'b0, key});
            if ($urandom_range(0, 3) != 0)
                add_key({1'b1, key});
        end
        else if (pick < 55)
        begin
            // lock key
            case ($urandom_range(0, 2))
                0: key = KEY_NUM;
                1: key = KEY_CAPS;
                default: key = KEY_SCROLL;
            endcase
            add_key({1'b0, key});
            add_key({1'b1, key});
        end
        else if (pick < 70)
        begin
            // Ctrl+Alt+Shift chord in a rotated order, then F12 in most bursts
            chord[0] = KEY_CTRL;
            chord[1] = KEY_ALT;
            chord[2] = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
            first = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                add_key({1'b0, chord[(first + i) % 3]});
            if ($urandom_range(0, 4) != 0)
            begin
                add_key({1'b0, KEY_F12});
                add_key({1'b1, KEY_F12});
            end
            if ($urandom_range(0, 3) != 0)
                for (int i = 0; i < 3; i++)
                    add_key({1'b1, chord[(first + i) % 3]});
        end
        else if (pick < 80)
        begin
            // lone modifier press or release
            case ($urandom_range(0, 3))
                0: key = KEY_LSHIFT;
                1: key = KEY_RSHIFT;
                2: key = KEY_CTRL;
                default: key = KEY_ALT;
            endcase
            add_key({1'($urandom_range(0, 1)), key});
        end
        else
        begin
            add_key(8'($urandom_range(0, 255)));
        end
    endtask

    // Driver: one transaction at a time from the pending queue
    always @(posedge clk)
    begin : drv
        logic        nxt_valid;
        logic [7:0]  nxt_data;
        logic        nxt_we;
        logic        nxt_wdata;
        stim_entry_t ent;
        nxt_valid = s_tvalid;
        nxt_data = s_tdata;
        nxt_we = 1'b0;
        nxt_wdata = cfg_wdata;
        if (rst_n)
        begin
            // accepted scan code transaction
            if (s_tvalid && s_tready)
            begin
                decoded_q.push_back(decode_scan(s_tdata));
                keys_sent++;
                nxt_valid = 1'b0;
                gap_left = $urandom_range(0, 3);
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    ent = pending_q[0];
                    if (ent.kind == ENT_KEY)
                    begin
                        nxt_valid = 1'b1;
                        nxt_data = ent.value;
                        void'(pending_q.pop_front());
                    end
                    else if (decoded_q.size() == 0 && !m_tvalid)
                    begin
                        // idle: let the pipeline settle before the write or the drain
                        if (settle_left < SETTLE_CYCLES)
                            settle_left++;
                        else
                        begin
                            settle_left = 0;
                            if (ent.kind == ENT_CFG)
                            begin
                                nxt_we = 1'b1;
                                nxt_wdata = ent.value[0];
                                dbg_mode = ent.value[0];
                            end
                            void'(pending_q.pop_front());
                        end
                    end
                    else
                        settle_left = 0;
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata <= nxt_data;
        cfg_we <= nxt_we;
        cfg_wdata <= nxt_wdata;
    end

    // Monitor: check each result transaction against the oldest prediction
    always @(posedge clk)
    begin : mon
        kbd_result_t got;
        kbd_result_t want;
        logic        nxt_ready;
        nxt_ready = m_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = kbd_result_t'(m_tdata[12:0]);
                if (decoded_q.size() == 0)
                begin
                    $error("result with no scan code outstanding: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("ascii_code", want.ascii_code, got.ascii_code);
                    check_field("is_release", want.is_release, got.is_release);
                    check_field("led_write", want.led_write, got.led_write);
                    check_field("led_bits", want.led_bits, got.led_bits);
                    check_field("hotkey", want.hotkey, got.hotkey);
                end
                results_seen++;
                // one long hold-off so the block backs up its input
                stall_left = (results_seen == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, 3);
                nxt_ready = (stall_left == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = (stall_left == 0);
            end
            else
                nxt_ready = 1'b1;
        end
        m_tready <= nxt_ready;
    end

    // Stimulus and end of run
    initial
    begin
        // directed: field extremes and table edges
        add_key(8'h00);
        add_key(8'hFF);
        add_key(8'h02);
        add_key(8'(TABLE_LEN - 1));
        add_key(8'(TABLE_LEN));
        add_key(8'h7F);
        // shift, then release through the other shift code
        add_key({1'b0, KEY_LSHIFT});
        add_key(8'h1E);
        add_key({1'b1, KEY_RSHIFT});
        add_key(8'h1E);
        // system locks, release does not toggle
        add_key({1'b0, KEY_NUM});
        add_key({1'b0, KEY_CAPS});
        add_key({1'b0, KEY_SCROLL});
        add_key({1'b1, KEY_NUM});
        // hotkey on F12 press only
        add_key({1'b0, KEY_CTRL});
        add_key({1'b0, KEY_ALT});
        add_key({1'b0, KEY_RSHIFT});
        add_key({1'b0, KEY_F12});
        add_key({1'b1, KEY_F12});
        add_key({1'b1, KEY_CTRL});
        add_key({1'b1, KEY_ALT});
        add_key({1'b1, KEY_RSHIFT});
        // debugger mode: own locks, caps flips the table, no hotkey
        add_cfg(1'b1);
        add_key({1'b0, KEY_CAPS});
        add_key(8'h10);
        add_key({1'b0, KEY_NUM});
        add_key({1'b0, KEY_SCROLL});

        // random phases over both modes
        for (int p = 0; p < PHASES; p++)
        begin
            add_cfg((p < 2) ? 1'(p) : 1'($urandom_range(0, 1)));
            while (keys_total < 27 + (p + 1) * PHASE_KEYS)
            begin
                add_burst();
                // sender waits once for every result before going on
                if (p == 3 && !drain_queued
                    && keys_total >= 27 + 3 * PHASE_KEYS + PHASE_KEYS / 2)
                begin
                    pending_q.push_back('{kind: ENT_DRAIN, value: 8'h00});
                    drain_queued = 1'b1;
                end
            end
        end

        // reset once
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        do
            @(negedge clk);
        while (keys_sent != keys_total || decoded_q.size() != 0);
        repeat (SETTLE_CYCLES + 5) @(negedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run limit
    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
